### src/bfd_pkg.sv
// Shared constants and types of the black frame detector.
// Depends on nothing; every other file of the block uses it by scoped names.
package bfd_pkg;

  // Default largest frame dimension in samples.
  localparam int unsigned MAX_DIM_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned LUMA_W = 8;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned FRM_W  = 32;
  localparam int unsigned OUT_W  = FRM_W + PCT_W + 1 + FRM_W;

  // Register indexes on the configuration port.
  localparam logic [ADDR_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [ADDR_W-1:0] REG_AMOUNT    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_WIDTH     = 2'd2;
  localparam logic [ADDR_W-1:0] REG_HEIGHT    = 2'd3;

  // Reset values of the registers.
  localparam logic [LUMA_W-1:0] THRESHOLD_RST = 8'd32;
  localparam logic [PCT_W-1:0]  AMOUNT_RST    = 7'd98;
  localparam logic [CFG_W-1:0]  WIDTH_RST     = 13'd1920;
  localparam logic [CFG_W-1:0]  HEIGHT_RST    = 13'd1080;

  // A full frame is one hundred percent.
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Status of the shared divider as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### src/bfd_cfg.sv
// Configuration registers and the registered frame size in samples.
// Depends on bfd_pkg.
module bfd_cfg #(
  parameter int unsigned MAX_DIM = bfd_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [bfd_pkg::ADDR_W-1:0]      addr_i,
  input  logic [bfd_pkg::CFG_W-1:0]       data_i,
  output logic [bfd_pkg::LUMA_W-1:0]      threshold_o,
  output logic [bfd_pkg::PCT_W-1:0]       amount_o,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] pixels_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned PixW = $clog2(MAX_DIM * MAX_DIM + 1);

  logic [bfd_pkg::LUMA_W-1:0] threshold_q, threshold_d;
  logic [bfd_pkg::PCT_W-1:0]  amount_q, amount_d;
  logic [bfd_pkg::CFG_W-1:0]  width_q, width_d;
  logic [bfd_pkg::CFG_W-1:0]  height_q, height_d;
  logic [PixW-1:0]            pixels_q, pixels_d;

  // A zero dimension counts as one, and anything above the maximum saturates.
  function automatic logic [DimW-1:0] clamp_dim(input logic [bfd_pkg::CFG_W-1:0] d);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (32'(d) > 32'(MAX_DIM)) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(d);
    end
    return r;
  endfunction

  always_comb begin
    threshold_d = threshold_q;
    amount_d    = amount_q;
    width_d     = width_q;
    height_d    = height_q;
    if (we_i) begin
      unique case (addr_i)
        bfd_pkg::REG_THRESHOLD: threshold_d = data_i[bfd_pkg::LUMA_W-1:0];
        bfd_pkg::REG_AMOUNT:    amount_d    = data_i[bfd_pkg::PCT_W-1:0];
        bfd_pkg::REG_WIDTH:     width_d     = data_i;
        bfd_pkg::REG_HEIGHT:    height_d    = data_i;
        default:                threshold_d = threshold_q;
      endcase
    end
    // The size product follows the new values, so it is valid the cycle after a write.
    pixels_d = PixW'(clamp_dim(width_d)) * PixW'(clamp_dim(height_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= bfd_pkg::THRESHOLD_RST;
      amount_q    <= bfd_pkg::AMOUNT_RST;
      width_q     <= bfd_pkg::WIDTH_RST;
      height_q    <= bfd_pkg::HEIGHT_RST;
      pixels_q    <= PixW'(clamp_dim(bfd_pkg::WIDTH_RST)) *
                     PixW'(clamp_dim(bfd_pkg::HEIGHT_RST));
    end else begin
      threshold_q <= threshold_d;
      amount_q    <= amount_d;
      width_q     <= width_d;
      height_q    <= height_d;
      pixels_q    <= pixels_d;
    end
  end

  assign threshold_o = threshold_q;
  assign amount_o    = amount_q;
  assign pixels_o    = pixels_q;

endmodule

### src/bfd_div.sv
// Shared compare-and-subtract unit that forms the black percentage one
// quotient bit per cycle. Depends on bfd_pkg.
module bfd_div #(
  parameter int unsigned CNT_W = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [CNT_W-1:0]            pixels_i,
  output bfd_pkg::div_status_t        status_o,
  output logic [bfd_pkg::PCT_W-1:0]   percent_o
);

  localparam int unsigned RemW  = CNT_W + bfd_pkg::PCT_W;
  localparam int unsigned QW    = bfd_pkg::PCT_W + 1;
  localparam int unsigned StepW = $clog2(QW);

  typedef enum logic {D_IDLE, D_RUN} dstate_e;

  dstate_e                  state_q;
  logic                     busy_q, done_q;
  logic [StepW-1:0]         step_q;
  logic [bfd_pkg::PCT_W-1:0] pct_q;
  logic [RemW-1:0]          rem_q, dv_q;
  logic [QW-1:0]            quo_q, quo_d;
  logic                     ge;

  // The quotient is built eight bits wide; a set top bit means well over one hundred.
  assign ge    = (rem_q >= dv_q);
  assign quo_d = {quo_q[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
      pct_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_RUN;
            busy_q  <= 1'b1;
            step_q  <= StepW'(QW - 1);
          end
        end
        D_RUN: begin
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= D_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
            pct_q   <= (quo_d > QW'(bfd_pkg::PCT_FULL)) ? bfd_pkg::PCT_FULL
                                                       : quo_d[bfd_pkg::PCT_W-1:0];
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE) begin
      if (start_i) begin
        rem_q <= RemW'(count_i) * RemW'(bfd_pkg::PCT_FULL);
        dv_q  <= {pixels_i, bfd_pkg::PCT_W'(0)};
        quo_q <= '0;
      end
    end else begin
      if (ge) begin
        rem_q <= rem_q - dv_q;
      end
      dv_q  <= dv_q >> 1;
      quo_q <= quo_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign percent_o     = pct_q;

endmodule

### src/black_frame_detector.sv
// Black frame detector: counts dark luma samples and reports one word per frame.
// Pixels are taken one per cycle while the block is ready; the last pixel of a frame
// starts an eight-step shared divider, and the block is not ready again until the
// result word is loaded, when the divider is done and the output is free;
// a word still waiting in the output register holds the block off until it drains.
// Asynchronous active-low reset clears counters and restores default registers.
module black_frame_detector #(
  parameter int unsigned MAX_DIM = bfd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bfd_pkg::ADDR_W-1:0]    cfg_addr_i,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_data_i,
  // Pixel input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bfd_pkg::LUMA_W-1:0]    s_axis_tdata_i,  // [7:0] luma
  input  logic                          s_axis_tuser_i,  // key_frame
  // Frame result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] frame_number, [38:32] black_percent, [39] is_black, [71:40] last_key_frame
  output logic [bfd_pkg::OUT_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned PixW = $clog2(MAX_DIM * MAX_DIM + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_e;

  state_e                     state_q;
  logic                       m_valid_q;
  logic [bfd_pkg::OUT_W-1:0]  m_data_q;

  logic [bfd_pkg::LUMA_W-1:0] threshold;
  logic [bfd_pkg::PCT_W-1:0]  amount;
  logic [PixW-1:0]            pixels;

  logic [PixW-1:0]            black_cnt_q, black_cnt_d;
  logic [PixW-1:0]            pix_pos_q;
  logic [bfd_pkg::FRM_W-1:0]  frame_cnt_q;
  logic [bfd_pkg::FRM_W-1:0]  key_num_q, key_num_d;
  logic [bfd_pkg::FRM_W-1:0]  pend_frame_q, pend_key_q;

  bfd_pkg::div_status_t       div_stat;
  logic [bfd_pkg::PCT_W-1:0]  percent;
  logic                       in_fire, last_pix, div_start, out_free, black_flag;
  logic                       load_out;

  bfd_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (cfg_we_i),
    .addr_i     (cfg_addr_i),
    .data_i     (cfg_data_i),
    .threshold_o(threshold),
    .amount_o   (amount),
    .pixels_o   (pixels)
  );

  // Pixels are taken only while no frame result is being worked out.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // The frame ends on the first pixel whose position reaches the frame size,
  // which also covers a size that shrank below the position mid-frame.
  assign last_pix  = !((pix_pos_q + PixW'(1)) < pixels);
  assign div_start = in_fire && last_pix;

  // The key-frame flag only counts on the first pixel of a frame.
  assign key_num_d   = ((pix_pos_q == '0) && s_axis_tuser_i) ? frame_cnt_q : key_num_q;
  assign black_cnt_d = black_cnt_q + PixW'(s_axis_tdata_i < threshold);

  bfd_div #(
    .CNT_W(PixW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (black_cnt_d),
    .pixels_i (pixels),
    .status_o (div_stat),
    .percent_o(percent)
  );

  // An amount above one hundred can never be reached, since the percentage saturates.
  assign black_flag = (percent >= amount);
  assign out_free   = !m_valid_q || m_axis_tready_i;

  // The finished word moves into the output register as soon as that register is free.
  assign load_out = ((state_q == S_OUT) || ((state_q == S_DIV) && div_stat.done)) && out_free;

  // Frame counters and the frame and key numbers of the frame being finished.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_cnt_q  <= '0;
      pix_pos_q    <= '0;
      frame_cnt_q  <= '0;
      key_num_q    <= '0;
      pend_frame_q <= '0;
      pend_key_q   <= '0;
    end else if (in_fire) begin
      key_num_q <= key_num_d;
      if (last_pix) begin
        black_cnt_q  <= '0;
        pix_pos_q    <= '0;
        frame_cnt_q  <= frame_cnt_q + bfd_pkg::FRM_W'(1);
        pend_frame_q <= frame_cnt_q;
        pend_key_q   <= key_num_d;
      end else begin
        black_cnt_q <= black_cnt_d;
        pix_pos_q   <= pix_pos_q + PixW'(1);
      end
    end
  end

  // Sequencer and output register. A finished word waits in the output register
  // while the next frame's pixels keep flowing in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (load_out) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {pend_key_q, black_flag, percent, pend_frame_q};
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV, S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end else if (div_stat.done) begin
            state_q <= S_OUT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A new word only appears once the divider has finished a frame.
  a_word_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == S_DIV || $past(state_q) == S_OUT))
    else $error("result word without a finished division");

  // Each pixel adds at most one to the black count.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    black_cnt_q <= pix_pos_q)
    else $error("black count exceeds pixel position");

  // The divider runs only while the sequencer waits for it.
  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV)
    else $error("divider busy outside the division state");

  // The last pixel of a frame starts the divider on the next edge.
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_stat.busy)
    else $error("frame end did not start the divider");

endmodule
